// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ilist_pkg.sv =====
// ---------------------------------------------------------------------------
// ilist_pkg
// Types and codes of the indexed list block.
// ---------------------------------------------------------------------------
package ilist_pkg;

	localparam int unsigned CAPACITY_DEF = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
		logic [5:0]         position;
	} ilist_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         length;
		logic               found;
		logic [4:0]         first_index;
		logic [5:0]         match_count;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
		logic               empty_res;
	} ilist_out_t;

	// search and range statistics of one scan
	typedef struct packed {
		logic               found;
		logic [4:0]         first_index;
		logic [5:0]         match_count;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
	} ilist_stats_t;

endpackage

// ===== hdl/ilist_mem.sv =====
// ---------------------------------------------------------------------------
// ilist_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ilist_mem #(
	parameter int unsigned DEPTH = ilist_pkg::CAPACITY_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ilist_scan.sv =====
// ---------------------------------------------------------------------------
// ilist_scan
// Accumulates match, first position, count, minimum and maximum over the
// entries streamed out of the store, one entry per cycle.
// ---------------------------------------------------------------------------
module ilist_scan #(
	parameter int unsigned CAPACITY = ilist_pkg::CAPACITY_DEF,
	parameter int unsigned AW       = $clog2(CAPACITY),
	parameter int unsigned LW       = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic signed [31:0]    key,
	input  logic                  valid,
	input  logic [AW-1:0]         idx,
	input  logic signed [31:0]    data,
	output ilist_pkg::ilist_stats_t stats
);

	logic               found_q;
	logic               seen_q;
	logic [AW-1:0]      first_q;
	logic [LW-1:0]      count_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic               hit;

	assign hit = (data == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			seen_q  <= 1'b0;
			first_q <= '0;
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (clear) begin
			found_q <= 1'b0;
			seen_q  <= 1'b0;
			first_q <= '0;
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (valid) begin
			seen_q <= 1'b1;
			if (hit) begin
				found_q <= 1'b1;
				count_q <= count_q + LW'(1);
				if (!found_q) begin
					first_q <= idx;
				end
			end
			// first entry seeds both extremes
			if (!seen_q || data < min_q) begin
				min_q <= data;
			end
			if (!seen_q || data > max_q) begin
				max_q <= data;
			end
		end
	end

	always_comb begin
		stats.found       = found_q;
		stats.first_index = 5'(first_q);
		stats.match_count = 6'(count_q);
		stats.min_value   = min_q;
		stats.max_value   = max_q;
	end

endmodule

// ===== hdl/indexed_list_insert_delete_search.sv =====
// ---------------------------------------------------------------------------
// indexed_list_insert_delete_search
// Ordered list of signed 32-bit entries with insert, delete and lookup.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Busy then stays high
// until the result is computed. The result shows on result for exactly one
// cycle with done high, in the first cycle with busy low, and the receiver
// cannot stall it. A new word may be taken in that same cycle. The list lives
// in one single-port-read, single-port-write memory, and every access goes
// through it one entry per cycle. An insert or delete first moves the entries
// behind the position, one per cycle, with read and write overlapped. An insert
// then writes the new value. Every word then scans the whole list to get the
// match, count, minimum and maximum. No clearing pass is needed after reset.
`include "assert_macros.svh"

module indexed_list_insert_delete_search #(
	parameter int unsigned CAPACITY = ilist_pkg::CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ilist_pkg::ilist_in_t  item,
	output logic                  done,
	output ilist_pkg::ilist_out_t result
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned CW = (LW > 6) ? LW : 6;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_PUT   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      cnt_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               shift_down_q;
	logic               put_q;
	logic [1:0]         status_q;
	logic signed [31:0] value_q;
	logic [5:0]         pos_q;

	logic               wr_v_s1;
	logic [AW-1:0]      wr_a_s1;
	logic               scan_v_s1;
	logic [AW-1:0]      scan_idx_s1;

	logic               accept;
	logic [CW-1:0]      len_ext;
	logic [CW-1:0]      pos_ext;
	logic               full;
	logic               rd_en;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic [31:0]        mem_rdata;
	logic               cnt_live;
	logic [1:0]         acc_status;
	logic               acc_ins;
	logic               acc_del;

	ilist_pkg::ilist_stats_t stats;
	ilist_pkg::ilist_out_t   result_q;
	logic                    done_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign len_ext  = CW'(len_q);
	assign pos_ext  = CW'(item.position);
	assign full     = (len_q == LW'(CAPACITY));
	assign cnt_live = (cnt_q != '0);
	assign rd_en    = (state_q inside {ST_SHIFT, ST_SCAN}) && cnt_live;

	// classify the incoming word: status and whether entries move
	always_comb begin
		acc_status = ilist_pkg::STATUS_OK;
		acc_ins    = 1'b0;
		acc_del    = 1'b0;
		case (item.mode)
			ilist_pkg::MODE_INSERT: begin
				if (full) begin
					acc_status = ilist_pkg::STATUS_FULL;
				end else if (pos_ext > len_ext) begin
					acc_status = ilist_pkg::STATUS_RANGE;
				end else begin
					acc_ins = 1'b1;
				end
			end
			ilist_pkg::MODE_DELETE: begin
				if (pos_ext >= len_ext) begin
					acc_status = ilist_pkg::STATUS_RANGE;
				end else begin
					acc_del = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// the new value goes in after the move; the move's writes trail its reads
	assign mem_we    = wr_v_s1 || (state_q == ST_PUT);
	assign mem_waddr = (state_q == ST_PUT) ? AW'(pos_q) : wr_a_s1;
	assign mem_wdata = (state_q == ST_PUT) ? value_q : mem_rdata;

	ilist_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_en),
		.raddr(rd_ptr_q),
		.rdata(mem_rdata)
	);

	ilist_scan #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.LW      (LW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (accept),
		.key   (value_q),
		.valid (scan_v_s1),
		.idx   (scan_idx_s1),
		.data  (mem_rdata),
		.stats (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			cnt_q        <= '0;
			rd_ptr_q     <= '0;
			shift_down_q <= 1'b0;
			put_q        <= 1'b0;
			status_q     <= ilist_pkg::STATUS_OK;
			wr_v_s1      <= 1'b0;
			scan_v_s1    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			wr_v_s1   <= (state_q == ST_SHIFT) && cnt_live;
			scan_v_s1 <= (state_q == ST_SCAN) && cnt_live;
			done_q    <= (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q     <= acc_status;
						put_q        <= acc_ins;
						shift_down_q <= acc_ins;
						if (acc_ins) begin
							len_q    <= len_q + LW'(1);
							cnt_q    <= LW'(len_ext - pos_ext);
							rd_ptr_q <= AW'(len_q - LW'(1));
							state_q  <= ST_SHIFT;
						end else if (acc_del) begin
							len_q    <= len_q - LW'(1);
							cnt_q    <= LW'(len_ext - pos_ext - CW'(1));
							rd_ptr_q <= AW'(pos_ext + CW'(1));
							state_q  <= ST_SHIFT;
						end else begin
							cnt_q    <= len_q;
							rd_ptr_q <= '0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SHIFT: begin
					if (cnt_live) begin
						cnt_q    <= cnt_q - LW'(1);
						rd_ptr_q <= shift_down_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
					end else if (put_q) begin
						state_q <= ST_PUT;
					end else begin
						cnt_q    <= len_q;
						rd_ptr_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_PUT: begin
					cnt_q    <= len_q;
					rd_ptr_q <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_live) begin
						cnt_q    <= cnt_q - LW'(1);
						rd_ptr_q <= rd_ptr_q + AW'(1);
					end else begin
						// last entry lands in the accumulators at this edge
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= item.value;
			pos_q   <= item.position;
		end
		wr_a_s1     <= shift_down_q ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
		scan_idx_s1 <= rd_ptr_q;
		if (state_q == ST_DONE) begin
			result_q.status      <= status_q;
			result_q.length      <= 6'(len_q);
			result_q.found       <= stats.found;
			result_q.first_index <= stats.first_index;
			result_q.match_count <= stats.match_count;
			result_q.min_value   <= stats.min_value;
			result_q.max_value   <= stats.max_value;
			result_q.empty_res   <= (len_q == '0);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after accepted word")
	`ASSERT_NEXT(a_single_done, done, !done, "more than one result for a word")
	`ASSERT_NOW(a_put_no_clash, state_q == ST_PUT, !wr_v_s1, "move write collides with insert")
	`ASSERT_NOW(a_write_busy, mem_we, busy, "entry write while idle")

endmodule
